// ----- hw/rtl/seirs_ode_integrator_step_assert.svh -----
// Assertion macros for the SEIRS integrator checker.
// Clocked on i_clk, disabled while i_rst_n is low.
`ifndef SEIRS_ODE_INTEGRATOR_STEP_ASSERT_SVH
`define SEIRS_ODE_INTEGRATOR_STEP_ASSERT_SVH

// same-cycle implication
`define SEIRS_AST_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("seirs check failed");

// next-cycle implication
`define SEIRS_AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("seirs check failed");

`endif

// ----- hw/rtl/seirs_pkg.sv -----
// Shared types, constants and the step microprogram of the SEIRS integrator.
// No dependencies.
package seirs_pkg;

    localparam int unsigned FRAC_BITS = 30;
    localparam int unsigned FIELD_W   = FRAC_BITS + 1;
    localparam int unsigned CFG_W     = 32;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned RATE_FRAC = 30;
    localparam int unsigned DT_FRAC   = 24;
    localparam int unsigned DIV_SH    = 65;

    localparam logic [CFG_IDX_W-1:0] CFG_WANING     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INFECTION  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INCUBATION = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_METHOD     = 3'd5;

    localparam logic OPC_STEP = 1'b0;
    localparam logic OPC_LOAD = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [FIELD_W-1:0] load_susceptible;
        logic [FIELD_W-1:0] load_exposed;
        logic [FIELD_W-1:0] load_infectious;
        logic [FIELD_W-1:0] load_recovered;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_W-1:0] susceptible_out;
        logic [FIELD_W-1:0] exposed_out;
        logic [FIELD_W-1:0] infectious_out;
        logic [FIELD_W-1:0] recovered_out;
    } t_out_item;

    typedef struct packed {
        logic [CFG_W-1:0] waning_rate;
        logic [CFG_W-1:0] infection_rate;
        logic [CFG_W-1:0] incubation_rate;
        logic [CFG_W-1:0] recovery_rate;
        logic [CFG_W-1:0] step_size;
        logic             method_select;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        waning_rate:     32'd2941758,
        infection_rate:  32'd536870912,
        incubation_rate: 32'd357913941,
        recovery_rate:   32'd153391689,
        step_size:       32'd16777216,
        method_select:   1'b1
    };

    localparam logic signed [63:0] IM_MAX   = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] RCP_SIX  = 64'sh5555_5555_5555_5556;

    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_MUL = 1'b1;

    localparam logic [2:0] SH_RATE = 3'd0;
    localparam logic [2:0] SH_DT   = 3'd1;
    localparam logic [2:0] SH_HALF = 3'd2;
    localparam logic [2:0] SH_FRAC = 3'd3;
    localparam logic [2:0] SH_DIV  = 3'd4;

    typedef struct packed {
        logic       op;
        logic       neg_b;
        logic [2:0] sh;
    } t_alu_cmd;

    typedef struct packed {
        logic start;
        logic load;
    } t_seq_req;

    // operand codes: bit 5 clear selects the register file
    localparam int unsigned RF_DEPTH = 26;
    localparam int unsigned RF_AW    = 5;
    localparam logic [5:0] R_T0  = 6'd0;
    localparam logic [5:0] R_K   = 6'd4;
    localparam logic [5:0] R_K1  = 6'd8;
    localparam logic [5:0] R_K2  = 6'd12;
    localparam logic [5:0] R_K3  = 6'd16;
    localparam logic [5:0] R_RR  = 6'd20;
    localparam logic [5:0] R_INF = 6'd21;
    localparam logic [5:0] R_SE  = 6'd22;
    localparam logic [5:0] R_GI  = 6'd23;
    localparam logic [5:0] R_X   = 6'd24;
    localparam logic [5:0] R_P   = 6'd25;
    localparam logic [5:0] C_Y0   = 6'd32;
    localparam logic [5:0] C_Y1   = 6'd33;
    localparam logic [5:0] C_Y2   = 6'd34;
    localparam logic [5:0] C_Y3   = 6'd35;
    localparam logic [5:0] C_RHO  = 6'd36;
    localparam logic [5:0] C_BETA = 6'd37;
    localparam logic [5:0] C_SIG  = 6'd38;
    localparam logic [5:0] C_GAM  = 6'd39;
    localparam logic [5:0] C_DT   = 6'd40;
    localparam logic [5:0] C_RCP  = 6'd41;

    typedef struct packed {
        t_alu_cmd   cmd;
        logic [5:0] src_a;
        logic [5:0] src_b;
        logic [5:0] dst;
        logic       last;
    } t_uop;

    localparam int unsigned PROG_LEN = 109;
    localparam int unsigned PC_W     = 7;
    localparam logic [PC_W-1:0] RK4_PC   = 7'd0;
    localparam logic [PC_W-1:0] EULER_PC = 7'd92;

    typedef t_uop [PROG_LEN-1:0] t_prog;

    function automatic t_uop mk_uop(logic op, logic neg_b, logic [2:0] sh,
                                    logic [5:0] a, logic [5:0] b, logic [5:0] d);
        t_uop u;
        u.cmd.op    = op;
        u.cmd.neg_b = neg_b;
        u.cmd.sh    = sh;
        u.src_a     = a;
        u.src_b     = b;
        u.dst       = d;
        u.last      = 1'b0;
        return u;
    endfunction

    // right-hand side of the model on y at base b, derivatives to base k
    function automatic t_prog add_rhs(t_prog pr, int p, logic [5:0] b, logic [5:0] k);
        t_prog q;
        q = pr;
        q[p+0] = mk_uop(ALU_MUL, 1'b0, SH_RATE, C_RHO,  b + 6'd3, R_RR);
        q[p+1] = mk_uop(ALU_MUL, 1'b0, SH_RATE, C_BETA, b,        R_X);
        q[p+2] = mk_uop(ALU_MUL, 1'b0, SH_FRAC, R_X,    b + 6'd2, R_INF);
        q[p+3] = mk_uop(ALU_MUL, 1'b0, SH_RATE, C_SIG,  b + 6'd1, R_SE);
        q[p+4] = mk_uop(ALU_MUL, 1'b0, SH_RATE, C_GAM,  b + 6'd2, R_GI);
        q[p+5] = mk_uop(ALU_ADD, 1'b1, SH_RATE, R_RR,  R_INF, k);
        q[p+6] = mk_uop(ALU_ADD, 1'b1, SH_RATE, R_INF, R_SE,  k + 6'd1);
        q[p+7] = mk_uop(ALU_ADD, 1'b1, SH_RATE, R_SE,  R_GI,  k + 6'd2);
        q[p+8] = mk_uop(ALU_ADD, 1'b1, SH_RATE, R_GI,  R_RR,  k + 6'd3);
        return q;
    endfunction

    function automatic t_prog build_prog();
        t_prog      pr;
        int         p;
        int         s;
        int         i;
        logic [5:0] k;
        logic [5:0] b;
        pr = '0;
        p  = 0;
        for (s = 0; s < 4; s++) begin
            k  = (s == 0) ? R_K1 : (s == 1) ? R_K2 : (s == 2) ? R_K3 : R_K;
            b  = (s == 0) ? C_Y0 : R_T0;
            pr = add_rhs(pr, p, b, k);
            p  = p + 9;
            if (s < 3) begin
                for (i = 0; i < 4; i++) begin
                    pr[p] = mk_uop(ALU_MUL, 1'b0, (s == 2) ? SH_DT : SH_HALF,
                                   C_DT, k + 6'(i), R_X);
                    pr[p+1] = mk_uop(ALU_ADD, 1'b0, SH_RATE, C_Y0 + 6'(i), R_X,
                                     R_T0 + 6'(i));
                    p = p + 2;
                end
            end
        end
        for (i = 0; i < 4; i++) begin
            pr[p+0] = mk_uop(ALU_ADD, 1'b0, SH_RATE, R_K1 + 6'(i), R_K + 6'(i), R_X);
            pr[p+1] = mk_uop(ALU_ADD, 1'b0, SH_RATE, R_K2 + 6'(i), R_K2 + 6'(i), R_P);
            pr[p+2] = mk_uop(ALU_ADD, 1'b0, SH_RATE, R_X, R_P, R_X);
            pr[p+3] = mk_uop(ALU_ADD, 1'b0, SH_RATE, R_K3 + 6'(i), R_K3 + 6'(i), R_P);
            pr[p+4] = mk_uop(ALU_ADD, 1'b0, SH_RATE, R_X, R_P, R_X);
            pr[p+5] = mk_uop(ALU_MUL, 1'b0, SH_DT,   C_DT, R_X, R_X);
            pr[p+6] = mk_uop(ALU_MUL, 1'b0, SH_DIV,  R_X, C_RCP, R_X);
            pr[p+7] = mk_uop(ALU_ADD, 1'b0, SH_RATE, C_Y0 + 6'(i), R_X, C_Y0 + 6'(i));
            p = p + 8;
        end
        pr[p-1].last = 1'b1;
        pr = add_rhs(pr, p, C_Y0, R_K1);
        p  = p + 9;
        for (i = 0; i < 4; i++) begin
            pr[p] = mk_uop(ALU_MUL, 1'b0, SH_DT, C_DT, R_K1 + 6'(i), R_X);
            pr[p+1] = mk_uop(ALU_ADD, 1'b0, SH_RATE, C_Y0 + 6'(i), R_X, C_Y0 + 6'(i));
            p = p + 2;
        end
        pr[p-1].last = 1'b1;
        return pr;
    endfunction

    localparam t_prog PROG = build_prog();

endpackage

// ----- hw/rtl/seirs_alu.sv -----
// Shared arithmetic unit: saturating add, and a 64x64 sign-magnitude
// multiply built from four 32x32 partial products. Uses seirs_pkg.
module seirs_alu
    import seirs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  t_alu_cmd           i_cmd,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output logic               o_done,
    output logic signed [63:0] o_res
);

    localparam logic signed [64:0] MAX65 = 65'(IM_MAX);

    logic               r_busy;
    logic [2:0]         r_cnt;
    logic               r_done;
    logic               r_ppv;
    logic [1:0]         r_pp_sh;
    logic [63:0]        r_pp;
    logic [63:0]        r_ma;
    logic [63:0]        r_mb;
    logic               r_neg;
    logic [2:0]         r_sh;
    logic [127:0]       r_acc;
    logic signed [63:0] r_res;

    logic signed [64:0] n_sum;
    logic signed [64:0] n_addend;
    logic signed [63:0] n_sat_sum;
    logic [63:0]        n_ma;
    logic [63:0]        n_mb;
    logic [31:0]        n_xa;
    logic [31:0]        n_xb;
    logic [127:0]       n_pp_ext;
    logic [127:0]       n_shifted;
    logic [63:0]        n_mag;
    logic signed [63:0] n_mul_res;

    always_comb begin
        n_addend = i_cmd.neg_b ? -{i_b[63], i_b} : {i_b[63], i_b};
        n_sum    = {i_a[63], i_a} + n_addend;
        if (n_sum > MAX65) begin
            n_sat_sum = IM_MAX;
        end else if (n_sum < -MAX65) begin
            n_sat_sum = -IM_MAX;
        end else begin
            n_sat_sum = n_sum[63:0];
        end
        n_ma = i_a[63] ? 64'(-i_a) : 64'(i_a);
        n_mb = i_b[63] ? 64'(-i_b) : 64'(i_b);
        n_xa = r_cnt[1] ? r_ma[63:32] : r_ma[31:0];
        n_xb = r_cnt[0] ? r_mb[63:32] : r_mb[31:0];
        unique case (r_pp_sh)
            2'd2:    n_pp_ext = {r_pp, 64'd0};
            2'd1:    n_pp_ext = {32'd0, r_pp, 32'd0};
            default: n_pp_ext = {64'd0, r_pp};
        endcase
        unique case (r_sh)
            SH_RATE: n_shifted = r_acc >> RATE_FRAC;
            SH_DT:   n_shifted = r_acc >> DT_FRAC;
            SH_HALF: n_shifted = r_acc >> (DT_FRAC + 1);
            SH_FRAC: n_shifted = r_acc >> FRAC_BITS;
            default: n_shifted = r_acc >> DIV_SH;
        endcase
        n_mag     = (|n_shifted[127:62]) ? 64'(IM_MAX) : {2'b00, n_shifted[61:0]};
        n_mul_res = r_neg ? -$signed(n_mag) : $signed(n_mag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
            r_ppv  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= (i_cmd.op == ALU_MUL);
                r_done <= (i_cmd.op == ALU_ADD);
                r_cnt  <= '0;
                r_ppv  <= 1'b0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                r_ppv <= (r_cnt <= 3'd3);
                if (r_cnt == 3'd5) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pp    <= 64'(n_xa) * 64'(n_xb);
        r_pp_sh <= {r_cnt[1] & r_cnt[0], r_cnt[1] ^ r_cnt[0]};
        if (i_start) begin
            r_ma  <= n_ma;
            r_mb  <= n_mb;
            r_neg <= i_a[63] ^ i_b[63];
            r_sh  <= i_cmd.sh;
            r_acc <= '0;
            if (i_cmd.op == ALU_ADD) begin
                r_res <= n_sat_sum;
            end
        end else if (r_busy) begin
            if (r_ppv) begin
                r_acc <= r_acc + n_pp_ext;
            end
            if (r_cnt == 3'd5) begin
                r_res <= n_mul_res;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ----- hw/rtl/seirs_seq.sv -----
// Microprogram sequencer, working register file and compartment state.
// Uses seirs_pkg and drives one seirs_alu.
module seirs_seq
    import seirs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_seq_req                 i_req,
    input  t_in_item                 i_item,
    input  t_cfg                     i_cfg,
    output logic                     o_done,
    output logic [3:0][FRAC_BITS:0]  o_comp
);

    localparam int unsigned CW = FRAC_BITS + 1;
    localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_ISSUE = 2'd2;
    localparam logic [1:0] ST_WAIT  = 2'd3;

    logic [1:0]           r_state;
    logic [PC_W-1:0]      r_pc;
    logic                 r_done;
    logic [3:0][CW-1:0]   r_comp;
    logic signed [63:0]   r_a;
    logic signed [63:0]   r_b;
    logic signed [63:0]   mem [RF_DEPTH];

    t_uop                 uop;
    logic                 alu_done;
    logic signed [63:0]   alu_res;
    logic signed [63:0]   n_spec_a;
    logic signed [63:0]   n_spec_b;
    logic [CW-1:0]        n_clamped;
    logic [3:0][CW-1:0]   n_loaded;
    logic [3:0][63:0]     n_load_raw;

    function automatic logic signed [63:0] spec(logic [5:0] c, logic [3:0][CW-1:0] comp,
                                                t_cfg cfg);
        logic signed [63:0] v;
        unique case (c)
            C_Y0:    v = $signed(64'(comp[0]));
            C_Y1:    v = $signed(64'(comp[1]));
            C_Y2:    v = $signed(64'(comp[2]));
            C_Y3:    v = $signed(64'(comp[3]));
            C_RHO:   v = $signed(64'(cfg.waning_rate));
            C_BETA:  v = $signed(64'(cfg.infection_rate));
            C_SIG:   v = $signed(64'(cfg.incubation_rate));
            C_GAM:   v = $signed(64'(cfg.recovery_rate));
            C_DT:    v = $signed(64'(cfg.step_size));
            C_RCP:   v = RCP_SIX;
            default: v = '0;
        endcase
        return v;
    endfunction

    assign uop = PROG[r_pc];

    always_comb begin
        n_spec_a = spec(uop.src_a, r_comp, i_cfg);
        n_spec_b = spec(uop.src_b, r_comp, i_cfg);
        if (alu_res < 0) begin
            n_clamped = '0;
        end else if (alu_res > ONE) begin
            n_clamped = ONE[CW-1:0];
        end else begin
            n_clamped = alu_res[CW-1:0];
        end
        n_load_raw[0] = 64'(i_item.load_susceptible);
        n_load_raw[1] = 64'(i_item.load_exposed);
        n_load_raw[2] = 64'(i_item.load_infectious);
        n_load_raw[3] = 64'(i_item.load_recovered);
        for (int i = 0; i < 4; i++) begin
            n_loaded[i] = (n_load_raw[i] > 64'(ONE)) ? ONE[CW-1:0] : n_load_raw[i][CW-1:0];
        end
    end

    seirs_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_ISSUE),
        .i_cmd   (uop.cmd),
        .i_a     (r_a),
        .i_b     (r_b),
        .o_done  (alu_done),
        .o_res   (alu_res)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == ST_WAIT && alu_done && !uop.dst[5]) begin
            mem[uop.dst[RF_AW-1:0]] <= alu_res;
        end
        if (r_state == ST_READ) begin
            r_a <= uop.src_a[5] ? n_spec_a : mem[uop.src_a[RF_AW-1:0]];
            r_b <= uop.src_b[5] ? n_spec_b : mem[uop.src_b[RF_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= '0;
            r_done  <= 1'b0;
            r_comp  <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_req.load) begin
                        r_comp <= n_loaded;
                        r_done <= 1'b1;
                    end else if (i_req.start) begin
                        r_pc    <= i_cfg.method_select ? RK4_PC : EULER_PC;
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_state <= ST_ISSUE;
                end
                ST_ISSUE: begin
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (alu_done) begin
                        if (uop.dst[5]) begin
                            r_comp[uop.dst[1:0]] <= n_clamped;
                        end
                        if (uop.last) begin
                            r_state <= ST_IDLE;
                            r_done  <= 1'b1;
                        end else begin
                            r_pc    <= r_pc + 7'd1;
                            r_state <= ST_READ;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_comp = r_comp;

endmodule

// ----- hw/rtl/seirs_ode_integrator_step.sv -----
// SEIRS integrator top level: config registers, item handshake, result register.
// Load item: the result passes the sequencer done flag, the pending flag and the
// output register. Step item: products and sums run one at a time on the shared
// unit: 40 products and 52 sums for RK4, 9 products and 8 sums for forward Euler.
// One item at a time; the next is taken once the result is in the output
// register. Synchronous active-low reset restores defaults, zeroes compartments.
module seirs_ode_integrator_step
    import seirs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item
);

    t_cfg                      r_cfg;
    logic                      r_busy;
    logic                      r_pend;
    logic                      r_out_valid;
    t_out_item                 r_out_item;

    logic                      in_acc;
    logic                      capture;
    t_seq_req                  seq_req;
    logic                      seq_done;
    logic [3:0][FRAC_BITS:0]   comp;

    assign in_acc        = i_in_valid && !r_busy;
    assign capture       = r_pend && (!r_out_valid || !i_out_stall);
    assign seq_req.start = in_acc && (i_in_item.opcode == OPC_STEP);
    assign seq_req.load  = in_acc && (i_in_item.opcode == OPC_LOAD);

    seirs_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (seq_req),
        .i_item  (i_in_item),
        .i_cfg   (r_cfg),
        .o_done  (seq_done),
        .o_comp  (comp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WANING:     r_cfg.waning_rate     <= i_cfg_data;
                CFG_INFECTION:  r_cfg.infection_rate  <= i_cfg_data;
                CFG_INCUBATION: r_cfg.incubation_rate <= i_cfg_data;
                CFG_RECOVERY:   r_cfg.recovery_rate   <= i_cfg_data;
                CFG_STEP_SIZE:  r_cfg.step_size       <= i_cfg_data;
                CFG_METHOD:     r_cfg.method_select   <= i_cfg_data[0];
                default:        r_cfg                 <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_busy <= 1'b1;
            end
            if (seq_done) begin
                r_pend <= 1'b1;
            end
            if (capture) begin
                r_pend      <= 1'b0;
                r_busy      <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (capture) begin
            r_out_item.susceptible_out <= FIELD_W'(comp[0]);
            r_out_item.exposed_out     <= FIELD_W'(comp[1]);
            r_out_item.infectious_out  <= FIELD_W'(comp[2]);
            r_out_item.recovered_out   <= FIELD_W'(comp[3]);
        end
    end

    assign o_in_stall  = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ----- hw/rtl/seirs_chk.sv -----
// Port-level checker for the SEIRS integrator, bound to the top level.
// Uses seirs_pkg and the assertion macro header.
`include "seirs_ode_integrator_step_assert.svh"

module seirs_chk
    import seirs_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    `SEIRS_AST_NXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)
    `SEIRS_AST_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item))
    `SEIRS_AST_IMP(a_out_from_item, $rose(o_out_valid), $past(o_in_stall))
    `SEIRS_AST_IMP(a_free_with_result, $fell(o_in_stall), o_out_valid)

endmodule

bind seirs_ode_integrator_step seirs_chk u_seirs_chk (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for seirs_ode_integrator_step: a fixed-point SEIRS
// predictor checks every item result. Depends on seirs_pkg and the block RTL.
module tb;
    import seirs_pkg::*;

    localparam int ONE_Q = 1 << 30;
    localparam int WDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    t_in_item    in_item;
    logic        out_valid;
    logic        out_stall;
    t_out_item   out_item;

    seirs_ode_integrator_step u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_idx), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_item(out_item)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    typedef struct {
        t_in_item   item;
        logic       has_golden;
        t_out_item  golden;
    } t_row;

    t_cfg       pred_cfg;
    longint     comp_st[4];
    t_out_item  pending_q[$];
    int         err_cnt;
    int         idle_cnt;
    bit         quiet;

    function automatic longint sat62(longint v);
        longint m = 64'sh3FFF_FFFF_FFFF_FFFF;
        if (v > m) return m;
        if (v < -m) return -m;
        return v;
    endfunction

    function automatic longint addq(longint a, longint b);
        return sat62(sat62(a) + sat62(b));
    endfunction

    function automatic longint mulq(longint a, longint b, int sh);
        logic [127:0] p;
        logic [127:0] r;
        bit neg;
        longint ua;
        longint ub;
        neg = (a < 0) != (b < 0);
        a = sat62(a);
        b = sat62(b);
        ua = a < 0 ? -a : a;
        ub = b < 0 ? -b : b;
        p = {64'd0, ua} * {64'd0, ub};
        r = p >> sh;
        if (r > 128'h3FFF_FFFF_FFFF_FFFF) r = 128'h3FFF_FFFF_FFFF_FFFF;
        return neg ? -longint'(r[63:0]) : longint'(r[63:0]);
    endfunction

    task automatic seirs_rates(input longint y[4], output longint k[4]);
        longint rr, inf, se, gi;
        rr  = mulq(longint'(pred_cfg.waning_rate), y[3], 30);
        inf = mulq(mulq(longint'(pred_cfg.infection_rate), y[0], 30), y[2], 30);
        se  = mulq(longint'(pred_cfg.incubation_rate), y[1], 30);
        gi  = mulq(longint'(pred_cfg.recovery_rate), y[2], 30);
        k[0] = addq(rr, -inf);
        k[1] = addq(inf, -se);
        k[2] = addq(se, -gi);
        k[3] = addq(gi, -rr);
    endtask

    task automatic integrate_step();
        longint y[4], k1[4], k2[4], k3[4], k4[4], t[4], nx[4];
        longint dt;
        longint s;
        dt = longint'(pred_cfg.step_size);
        y = comp_st;
        seirs_rates(y, k1);
        if (!pred_cfg.method_select) begin
            for (int i = 0; i < 4; i++) nx[i] = addq(y[i], mulq(dt, k1[i], 24));
        end else begin
            for (int i = 0; i < 4; i++) t[i] = addq(y[i], mulq(dt, k1[i], 25));
            seirs_rates(t, k2);
            for (int i = 0; i < 4; i++) t[i] = addq(y[i], mulq(dt, k2[i], 25));
            seirs_rates(t, k3);
            for (int i = 0; i < 4; i++) t[i] = addq(y[i], mulq(dt, k3[i], 24));
            seirs_rates(t, k4);
            for (int i = 0; i < 4; i++) begin
                s = addq(k1[i], k4[i]);
                s = addq(s, addq(k2[i], k2[i]));
                s = addq(s, addq(k3[i], k3[i]));
                nx[i] = addq(y[i], mulq(dt, s, 24) / 6);
            end
        end
        for (int i = 0; i < 4; i++)
            comp_st[i] = nx[i] < 0 ? 0 : (nx[i] > ONE_Q ? ONE_Q : nx[i]);
    endtask

    function automatic longint load_clip(logic [30:0] v);
        return v > ONE_Q ? ONE_Q : longint'(v);
    endfunction

    task automatic predict_item(input t_in_item it);
        t_out_item r;
        if (it.opcode == OPC_LOAD) begin
            comp_st[0] = load_clip(it.load_susceptible);
            comp_st[1] = load_clip(it.load_exposed);
            comp_st[2] = load_clip(it.load_infectious);
            comp_st[3] = load_clip(it.load_recovered);
        end else begin
            integrate_step();
        end
        r.susceptible_out = comp_st[0][30:0];
        r.exposed_out     = comp_st[1][30:0];
        r.infectious_out  = comp_st[2][30:0];
        r.recovered_out   = comp_st[3][30:0];
        pending_q.push_back(r);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_WANING:     pred_cfg.waning_rate = val;
            CFG_INFECTION:  pred_cfg.infection_rate = val;
            CFG_INCUBATION: pred_cfg.incubation_rate = val;
            CFG_RECOVERY:   pred_cfg.recovery_rate = val;
            CFG_STEP_SIZE:  pred_cfg.step_size = val;
            CFG_METHOD:     pred_cfg.method_select = val[0];
            default: ;
        endcase
    endtask

    task automatic send_item(input t_in_item it);
        @(negedge clk);
        while (!quiet && $urandom_range(99) < 28) @(negedge clk);
        in_valid = 1'b1;
        in_item = it;
        do @(posedge clk); while (in_stall);
        predict_item(it);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic drain();
        while (pending_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [30:0] rand_frac();
        case ($urandom_range(5))
            0: return 31'd0;
            1: return 31'(ONE_Q);
            2: return 31'($urandom);
            default: return 31'($urandom_range(ONE_Q));
        endcase
    endfunction

    function automatic t_in_item mk_load(logic [30:0] s, logic [30:0] e,
                                         logic [30:0] i, logic [30:0] r);
        t_in_item it;
        it.opcode = OPC_LOAD;
        it.load_susceptible = s;
        it.load_exposed = e;
        it.load_infectious = i;
        it.load_recovered = r;
        return it;
    endfunction

    function automatic t_in_item mk_step();
        t_in_item it;
        it = mk_load(31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom));
        it.opcode = OPC_STEP;
        return it;
    endfunction

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected item %h", $time, out_item);
                err_cnt++;
            end else begin
                if (pending_q[0] !== out_item) begin
                    $display("%0t: mismatch expected %h actual %h",
                             $time, pending_q[0], out_item);
                    err_cnt++;
                end
                void'(pending_q.pop_front());
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt > WDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(negedge clk) begin
        out_stall <= (!quiet && $urandom_range(99) < 28);
    end

    t_row dir_tbl[$];

    initial begin
        t_row row;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        err_cnt = 0;
        idle_cnt = 0;
        quiet = 1'b0;
        pred_cfg = CFG_RESET;
        comp_st = '{0, 0, 0, 0};
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        row.has_golden = 1'b1;
        row.item = mk_step();
        row.golden = '0;
        dir_tbl.push_back(row);
        row.item = mk_load(31'h7FFF_FFFF, 31'(ONE_Q), 31'(ONE_Q + 1), 31'd0);
        row.golden = {31'(ONE_Q), 31'(ONE_Q), 31'(ONE_Q), 31'd0};
        dir_tbl.push_back(row);
        row.item = mk_load(31'd996 << 20, 31'd0, 31'd28 << 20, 31'd0);
        row.golden = {31'd996 << 20, 31'd0, 31'd28 << 20, 31'd0};
        dir_tbl.push_back(row);
        row.has_golden = 1'b0;
        for (int n = 0; n < 4; n++) begin
            row.item = mk_step();
            dir_tbl.push_back(row);
        end

        foreach (dir_tbl[n]) begin
            send_item(dir_tbl[n].item);
            if (dir_tbl[n].has_golden && pending_q[$] !== dir_tbl[n].golden) begin
                $display("%0t: table mismatch expected %h actual %h",
                         $time, dir_tbl[n].golden, pending_q[$]);
                err_cnt++;
            end
        end
        drain();

        write_reg(CFG_METHOD, 32'd0);
        for (int n = 0; n < 4; n++) send_item(mk_step());
        drain();
        write_reg(CFG_STEP_SIZE, 32'd0);
        write_reg(CFG_METHOD, 32'hFFFF_FFFE);
        send_item(mk_load(31'd1 << 28, 31'd1 << 28, 31'd1 << 28, 31'd1 << 28));
        send_item(mk_step());
        drain();
        write_reg(CFG_WANING, 32'hFFFF_FFFF);
        write_reg(CFG_INFECTION, 32'hFFFF_FFFF);
        write_reg(CFG_INCUBATION, 32'hFFFF_FFFF);
        write_reg(CFG_RECOVERY, 32'hFFFF_FFFF);
        write_reg(CFG_STEP_SIZE, 32'hFFFF_FFFF);
        write_reg(CFG_METHOD, 32'd1);
        send_item(mk_step());
        send_item(mk_step());
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            quiet = (ph == 5);
            write_reg(CFG_WANING, $urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 28));
            write_reg(CFG_INFECTION, $urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 31));
            write_reg(CFG_INCUBATION, $urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 30));
            write_reg(CFG_RECOVERY, $urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 29));
            write_reg(CFG_STEP_SIZE, ph == 3 ? 32'd1 :
                      ($urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 26)));
            write_reg(CFG_METHOD, $urandom);
            for (int n = 0; n < 50; n++) begin
                if ($urandom_range(9) < 2)
                    send_item(mk_load(rand_frac(), rand_frac(), rand_frac(), rand_frac()));
                else
                    send_item(mk_step());
            end
            drain();
        end
        quiet = 1'b0;

        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/seirs_pkg.sv
hw/rtl/seirs_alu.sv
hw/rtl/seirs_seq.sv
hw/rtl/seirs_ode_integrator_step.sv
hw/rtl/seirs_chk.sv
tb/tb.sv
